>>> rtl/cl3_pkg.sv
// ----------------------------------------------------------------------------
// cl3_pkg
// Shared constants, codes and controller/datapath types of the 3d color lut.
// ----------------------------------------------------------------------------
package cl3_pkg;

  localparam int MAX_GRID     = 17;
  localparam int MAX_CHANNELS = 6;
  localparam int LUT_DEPTH    = MAX_GRID * MAX_GRID * MAX_GRID * MAX_CHANNELS;

  localparam int ADDR_W     = 15;
  localparam int WORD_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int CHAN_W     = 3;
  localparam int STEP_W     = 4;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE     = 3'd0,
    CFG_CHANNEL_COUNT = 3'd1,
    CFG_INTERP_MODE   = 3'd2,
    CFG_CHANNEL_MAP   = 3'd3,
    CFG_OUT_CAPACITY  = 3'd4
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic              accept;
    logic              load;
    logic              setup;
    logic              fetch;
    logic              calc;
    logic              zero_res;
    logic [STEP_W-1:0] step;
    logic [CHAN_W-1:0] chan;
  } cl3_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              lookup_ok;
    logic              map_ok;
    logic [CHAN_W-1:0] last_chan;
  } cl3_status_t;

endpackage

>>> rtl/cl3_if.sv
// ----------------------------------------------------------------------------
// cl3 channel interfaces
// Valid/ready channels for lookup input items and channel result items.
// ----------------------------------------------------------------------------
interface cl3_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [cl3_pkg::ADDR_W-1:0]  lut_addr;
  logic [cl3_pkg::WORD_W-1:0]  lut_word;
  logic [cl3_pkg::WORD_W-1:0]  red_in;
  logic [cl3_pkg::WORD_W-1:0]  green_in;
  logic [cl3_pkg::WORD_W-1:0]  blue_in;

  modport source (output valid, cmd, lut_addr, lut_word, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, cmd, lut_addr, lut_word, red_in, green_in, blue_in,
                output ready);
endinterface

interface cl3_out_if;
  logic                        valid;
  logic                        ready;
  logic [cl3_pkg::CHAN_W-1:0]  chan_index;
  logic [cl3_pkg::WORD_W-1:0]  chan_value;
  logic                        last;

  modport source (output valid, chan_index, chan_value, last, input ready);
  modport sink (input valid, chan_index, chan_value, last, output ready);
endinterface

>>> rtl/cl3_ctrl.sv
// ----------------------------------------------------------------------------
// cl3_ctrl
// Sequencer: setup, per-channel corner fetch, interpolation steps, emit.
// ----------------------------------------------------------------------------
module cl3_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_cmd,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_last,
  output logic [cl3_pkg::CHAN_W-1:0]   out_chan,
  input  cl3_pkg::cl3_status_t         st,
  output cl3_pkg::cl3_cmd_t            ctl
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_CHAN  = 6'b000100,
    S_FETCH = 6'b001000,
    S_CALC  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  localparam logic [cl3_pkg::STEP_W-1:0] SETUP_LAST = 4'd2;
  localparam logic [cl3_pkg::STEP_W-1:0] FETCH_LAST = 4'd8;
  localparam logic [cl3_pkg::STEP_W-1:0] CALC_LAST  = 4'd6;

  state_t                        state_r, state_nxt;
  logic [cl3_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [cl3_pkg::CHAN_W-1:0]    chan_r, chan_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      chan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chan_r  <= chan_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    chan_nxt     = chan_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    ctl          = '0;
    ctl.step     = cnt_r;
    ctl.chan     = chan_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (in_cmd == cl3_pkg::CMD_LOAD) begin
            ctl.load = 1'b1;
          end else begin
            state_nxt = S_SETUP;
            cnt_nxt   = '0;
          end
        end
      end
      S_SETUP: begin
        ctl.setup = 1'b1;
        if (cnt_r == SETUP_LAST) begin
          chan_nxt  = '0;
          state_nxt = st.lookup_ok ? S_CHAN : S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_CHAN: begin
        cnt_nxt = '0;
        if (st.map_ok) begin
          state_nxt = S_FETCH;
        end else begin
          ctl.zero_res = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_FETCH: begin
        ctl.fetch = 1'b1;
        if (cnt_r == FETCH_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_CALC;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_CALC: begin
        ctl.calc = 1'b1;
        if (cnt_r == CALC_LAST) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (chan_r == st.last_chan) begin
            state_nxt = S_IDLE;
          end else begin
            chan_nxt  = chan_r + 3'd1;
            state_nxt = S_CHAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_chan = chan_r;
  assign out_last = (chan_r == st.last_chan);

endmodule

>>> rtl/cl3_dp.sv
// ----------------------------------------------------------------------------
// cl3_dp
// Datapath: config registers, table memory, cell split, corner registers and
// one shared blend / scaled-difference unit.
// ----------------------------------------------------------------------------
module cl3_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cl3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cl3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [cl3_pkg::ADDR_W-1:0]       in_lut_addr,
  input  logic [cl3_pkg::WORD_W-1:0]       in_lut_word,
  input  logic [cl3_pkg::WORD_W-1:0]       in_red,
  input  logic [cl3_pkg::WORD_W-1:0]       in_green,
  input  logic [cl3_pkg::WORD_W-1:0]       in_blue,
  input  cl3_pkg::cl3_cmd_t                ctl,
  output cl3_pkg::cl3_status_t             st,
  output logic [cl3_pkg::WORD_W-1:0]       res_value
);

  localparam logic [2:0] PATH_RGB = 3'd0;  // r >= g >= b
  localparam logic [2:0] PATH_RBG = 3'd1;
  localparam logic [2:0] PATH_BRG = 3'd2;
  localparam logic [2:0] PATH_BGR = 3'd3;
  localparam logic [2:0] PATH_GBR = 3'd4;
  localparam logic [2:0] PATH_GRB = 3'd5;

  localparam logic [1:0] AX_R = 2'd0;
  localparam logic [1:0] AX_G = 2'd1;
  localparam logic [1:0] AX_B = 2'd2;

  // configuration
  logic [4:0]  grid_r;
  logic [2:0]  chcnt_r;
  logic        mode_r;
  logic [17:0] map_r;
  logic [2:0]  cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r  <= 5'd17;
      chcnt_r <= 3'd3;
      mode_r  <= 1'b0;
      map_r   <= 18'd181896;
      cap_r   <= 3'd6;
    end else if (cfg_we) begin
      case (cl3_pkg::cfg_idx_t'(cfg_index))
        cl3_pkg::CFG_GRID_SIZE:     grid_r  <= cfg_data[4:0];
        cl3_pkg::CFG_CHANNEL_COUNT: chcnt_r <= cfg_data[2:0];
        cl3_pkg::CFG_INTERP_MODE:   mode_r  <= cfg_data[0];
        cl3_pkg::CFG_CHANNEL_MAP:   map_r   <= cfg_data;
        cl3_pkg::CFG_OUT_CAPACITY:  cap_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [2:0] sc;
  logic [2:0] nres;

  assign sc   = map_r[3*ctl.chan +: 3];
  assign nres = (chcnt_r < cap_r) ? chcnt_r : cap_r;

  assign st.lookup_ok = (grid_r >= 5'd2) && (grid_r <= 5'(cl3_pkg::MAX_GRID)) &&
                        (chcnt_r >= 3'd3) && (chcnt_r <= 3'(cl3_pkg::MAX_CHANNELS)) &&
                        (nres != 3'd0);
  assign st.map_ok    = (sc < chcnt_r);
  assign st.last_chan = nres - 3'd1;

  // index and fraction of one axis; the top input lands in the last cell
  function automatic logic [19:0] split_axis(input logic [20:0] pos, input logic [4:0] g1);
    logic [4:0]  q0;
    logic [16:0] t;
    logic [4:0]  i;
    logic [15:0] r;
    q0 = pos[20:16];
    t  = {1'b0, pos[15:0]} + {12'b0, q0};
    if (t >= 17'd65535) begin
      i = q0 + 5'd1;
      r = 16'(t - 17'd65535);
    end else begin
      i = q0;
      r = t[15:0];
    end
    if (i >= g1) begin
      i = g1 - 5'd1;
      r = 16'hFFFF;
    end
    return {i[3:0], r};
  endfunction

  // rounded frac * 256 / 65535
  function automatic logic [8:0] to_q8(input logic [15:0] f);
    logic [24:0] n;
    logic [8:0]  q0;
    logic [16:0] t;
    n  = {1'b0, f, 8'b0} + 25'd32767;
    q0 = n[24:16];
    t  = {1'b0, n[15:0]} + {8'b0, q0};
    return (t >= 17'd65535) ? q0 + 9'd1 : q0;
  endfunction

  // tetrahedron edge j of a path: {lower corner, upper corner, axis}
  function automatic logic [7:0] tet_edge(input logic [2:0] path, input logic [1:0] j);
    logic [7:0] e;
    e = '0;
    case (path)
      PATH_RGB: case (j)
        2'd0: e = {3'd0, 3'd4, AX_R};
        2'd1: e = {3'd4, 3'd6, AX_G};
        default: e = {3'd6, 3'd7, AX_B};
      endcase
      PATH_RBG: case (j)
        2'd0: e = {3'd0, 3'd4, AX_R};
        2'd1: e = {3'd4, 3'd5, AX_B};
        default: e = {3'd5, 3'd7, AX_G};
      endcase
      PATH_BRG: case (j)
        2'd0: e = {3'd0, 3'd1, AX_B};
        2'd1: e = {3'd1, 3'd5, AX_R};
        default: e = {3'd5, 3'd7, AX_G};
      endcase
      PATH_BGR: case (j)
        2'd0: e = {3'd0, 3'd1, AX_B};
        2'd1: e = {3'd1, 3'd3, AX_G};
        default: e = {3'd3, 3'd7, AX_R};
      endcase
      PATH_GBR: case (j)
        2'd0: e = {3'd0, 3'd2, AX_G};
        2'd1: e = {3'd2, 3'd3, AX_B};
        default: e = {3'd3, 3'd7, AX_R};
      endcase
      default: case (j)
        2'd0: e = {3'd0, 3'd2, AX_G};
        2'd1: e = {3'd2, 3'd6, AX_R};
        default: e = {3'd6, 3'd7, AX_B};
      endcase
    endcase
    return e;
  endfunction

  // captured color and setup results
  logic [15:0] red_r, green_r, blue_r;
  logic [20:0] rpos_r, gpos_r, bpos_r;
  logic [3:0]  ri_r, gi_r, bi_r;
  logic [15:0] rf_r, gf_r, bf_r;
  logic [8:0]  r8_r, g8_r, b8_r;
  logic [7:0]  sg_r;
  logic [11:0] sr_r;
  logic [14:0] base_r;
  logic [2:0]  path_r;
  logic [4:0]  gs1;
  logic [19:0] rsplit, gsplit, bsplit;
  logic [2:0]  path_c;

  assign gs1    = grid_r - 5'd1;
  assign rsplit = split_axis(rpos_r, gs1);
  assign gsplit = split_axis(gpos_r, gs1);
  assign bsplit = split_axis(bpos_r, gs1);

  always_comb begin
    if (rf_r >= gf_r) begin
      if (gf_r >= bf_r)      path_c = PATH_RGB;
      else if (rf_r >= bf_r) path_c = PATH_RBG;
      else                   path_c = PATH_BRG;
    end else begin
      if (bf_r >= gf_r)      path_c = PATH_BGR;
      else if (bf_r >= rf_r) path_c = PATH_GBR;
      else                   path_c = PATH_GRB;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    if (ctl.setup) begin
      case (ctl.step)
        4'd0: begin
          rpos_r <= 21'(red_r * gs1);
          gpos_r <= 21'(green_r * gs1);
          bpos_r <= 21'(blue_r * gs1);
          sg_r   <= 8'(grid_r * chcnt_r);
        end
        4'd1: begin
          {ri_r, rf_r} <= rsplit;
          {gi_r, gf_r} <= gsplit;
          {bi_r, bf_r} <= bsplit;
          sr_r         <= 12'(grid_r * sg_r);
        end
        default: begin
          r8_r   <= to_q8(rf_r);
          g8_r   <= to_q8(gf_r);
          b8_r   <= to_q8(bf_r);
          path_r <= path_c;
          base_r <= 15'(ri_r * sr_r + gi_r * sg_r + bi_r * chcnt_r);
        end
      endcase
    end
  end

  // table memory, one port shared by load writes and corner reads
  logic [15:0] mem [cl3_pkg::LUT_DEPTH];
  logic [15:0] rd_r;
  logic [14:0] fetch_addr;
  logic [14:0] mem_addr;
  logic        mem_we;
  logic [2:0]  corner;

  assign corner     = ctl.step[2:0];
  assign fetch_addr = base_r + {12'b0, sc}
                    + (corner[2] ? {3'b0, sr_r} : 15'd0)
                    + (corner[1] ? {7'b0, sg_r} : 15'd0)
                    + (corner[0] ? {12'b0, chcnt_r} : 15'd0);
  assign mem_addr   = ctl.load ? in_lut_addr : fetch_addr;
  assign mem_we     = ctl.load && (in_lut_addr < 15'(cl3_pkg::LUT_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_lut_word;
    end else begin
      rd_r <= mem[mem_addr];
    end
  end

  // corner words, later reused as trilinear partial sums
  logic [7:0][15:0] corners_r;
  logic [2:0]       cap_idx;

  assign cap_idx = 3'(ctl.step - 4'd1);

  // shared arithmetic
  logic [2:0]          la, lb;
  logic [8:0]          w8;
  logic [15:0]         opa, opb;
  logic signed [16:0]  diff;
  logic signed [26:0]  bmul, bsh;
  logic [15:0]         blend;
  logic [7:0]          edge_sel;
  logic [15:0]         efrac;
  logic signed [33:0]  prod_r;
  logic [33:0]         pmag, pn;
  logic [17:0]         q0, qv;
  logic [18:0]         qt;
  logic signed [19:0]  acc_r;
  logic [15:0]         res_r;

  assign edge_sel = tet_edge(path_r, ctl.step[2:1]);

  always_comb begin
    la = 3'd0;
    lb = 3'd1;
    w8 = b8_r;
    if (mode_r) begin
      la = edge_sel[7:5];
      lb = edge_sel[4:2];
    end else begin
      case (ctl.step[2:0])
        3'd0: begin la = 3'd0; lb = 3'd1; w8 = b8_r; end
        3'd1: begin la = 3'd2; lb = 3'd3; w8 = b8_r; end
        3'd2: begin la = 3'd4; lb = 3'd5; w8 = b8_r; end
        3'd3: begin la = 3'd6; lb = 3'd7; w8 = b8_r; end
        3'd4: begin la = 3'd0; lb = 3'd2; w8 = g8_r; end
        3'd5: begin la = 3'd4; lb = 3'd6; w8 = g8_r; end
        default: begin la = 3'd0; lb = 3'd4; w8 = r8_r; end
      endcase
    end
    case (edge_sel[1:0])
      AX_R:    efrac = rf_r;
      AX_G:    efrac = gf_r;
      default: efrac = bf_r;
    endcase
  end

  assign opa   = corners_r[la];
  assign opb   = corners_r[lb];
  assign diff  = $signed({1'b0, opb}) - $signed({1'b0, opa});
  assign bmul  = diff * $signed({1'b0, w8});
  assign bsh   = (bmul + 27'sd128) >>> 8;
  assign blend = opa + bsh[15:0];

  // rounded |p| / 65535, quotient correction of up to two
  assign pmag = prod_r[33] ? 34'(-prod_r) : prod_r;
  assign pn   = pmag + 34'd32767;
  assign q0   = pn[33:16];
  assign qt   = {3'b0, pn[15:0]} + {1'b0, q0};
  assign qv   = q0 + ((qt >= 19'd131070) ? 18'd2 : (qt >= 19'd65535) ? 18'd1 : 18'd0);

  always_ff @(posedge clk) begin
    if (ctl.fetch && ctl.step != 4'd0) begin
      corners_r[cap_idx] <= rd_r;
    end
    if (ctl.zero_res) begin
      res_r <= '0;
    end
    if (ctl.calc) begin
      if (mode_r) begin
        if (ctl.step == 4'd6) begin
          if (acc_r <= 20'sd0)          res_r <= 16'd0;
          else if (acc_r >= 20'sd65535) res_r <= 16'hFFFF;
          else                          res_r <= acc_r[15:0];
        end else if (!ctl.step[0]) begin
          prod_r <= 34'(diff * $signed({1'b0, efrac}));
          if (ctl.step == 4'd0) begin
            acc_r <= $signed({4'b0, corners_r[0]});
          end
        end else begin
          acc_r <= prod_r[33] ? acc_r - $signed({2'b0, qv}) : acc_r + $signed({2'b0, qv});
        end
      end else begin
        if (ctl.step == 4'd6) res_r <= blend;
        else                  corners_r[la] <= blend;
      end
    end
  end

  assign res_value = res_r;

endmodule

>>> rtl/color_lut3d_interpolator.sv
// load item: the table word is written at the accept edge
// lookup item: accept and setup, then for each channel that reads the table a select
// step, eight corner reads through the single table port, interpolation steps and an emit
// that holds until the result is taken; a channel mapped past the stored count is only
// selected and emitted; a lookup under out-of-range settings ends after setup, emits nothing
// synchronous active-low reset returns config to defaults; table is not cleared
// ----------------------------------------------------------------------------
// color_lut3d_interpolator
// 3d color table with trilinear or tetrahedral interpolation per channel.
// ----------------------------------------------------------------------------
module color_lut3d_interpolator (
  input  logic                             clk,
  input  logic                             rst_n,
  cl3_in_if.sink                           in_if,
  cl3_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [cl3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cl3_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cl3_pkg::cl3_cmd_t    ctl;
  cl3_pkg::cl3_status_t st;

  cl3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_cmd    (in_if.cmd),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_last  (out_if.last),
    .out_chan  (out_if.chan_index),
    .st        (st),
    .ctl       (ctl)
  );

  cl3_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_lut_addr (in_if.lut_addr),
    .in_lut_word (in_if.lut_word),
    .in_red      (in_if.red_in),
    .in_green    (in_if.green_in),
    .in_blue     (in_if.blue_in),
    .ctl         (ctl),
    .st          (st),
    .res_value   (out_if.chan_value)
  );

endmodule

>>> bench/color_lut3d_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_lut3d_interpolator_tb
// Fills the color table through load items, then sends directed and random
// lookups under changing grid, channel, map, capacity and interpolation
// settings; every result item is checked against an in-bench prediction.
// ----------------------------------------------------------------------------
module color_lut3d_interpolator_tb;

  typedef struct {
    logic [cl3_pkg::CHAN_W-1:0] chan_index;
    logic [cl3_pkg::WORD_W-1:0] chan_value;
    logic                       last;
  } chan_result_t;

  // table words covered by grids up to 3 with up to six channels
  localparam int FILL_WORDS = 3 * 3 * 3 * cl3_pkg::MAX_CHANNELS;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [cl3_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cl3_pkg::CFG_DATA_W-1:0] cfg_data;

  cl3_in_if  in_ch();
  cl3_out_if out_ch();

  color_lut3d_interpolator dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block's table and registers
  logic [cl3_pkg::WORD_W-1:0] lut_shadow [cl3_pkg::LUT_DEPTH];
  int unsigned grid_q, chans_q, mode_q, map_q, cap_q;

  chan_result_t expected_q[$];
  int errors = 0;
  int n_lookups = 0, n_loads = 0, n_results = 0, n_settings = 0;
  bit idle_en = 1'b0;
  int stall_cnt = 0;

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned blend8(int unsigned a, int unsigned b, int unsigned w);
    return ((a * (256 - w) + b * w + 128) >> 8) & 32'hffff;
  endfunction

  function automatic int scaled_step(int d, int unsigned f);
    longint p;
    p = longint'(d) * longint'(f);
    if (p >= 0) return int'((p + 32767) / 65535);
    return -int'((-p + 32767) / 65535);
  endfunction

  task automatic predict_lookup(input logic [15:0] r, input logic [15:0] g,
                                input logic [15:0] b);
    int unsigned gs1, pos, sb, sg, sr, base, n, sc, o, val;
    int unsigned ix[3], fr[3], w8[3];
    int unsigned c[3];
    int v[8];
    int acc;
    chan_result_t res;
    if (grid_q < 2 || grid_q > cl3_pkg::MAX_GRID) return;
    if (chans_q < 3 || chans_q > cl3_pkg::MAX_CHANNELS) return;
    n = (chans_q < cap_q) ? chans_q : cap_q;
    if (n == 0) return;
    gs1 = grid_q - 1;
    c[0] = r; c[1] = g; c[2] = b;
    for (int k = 0; k < 3; k++) begin
      pos = c[k] * gs1;
      ix[k] = pos / 65535;
      if (ix[k] > gs1 - 1) ix[k] = gs1 - 1;
      fr[k] = pos - ix[k] * 65535;
      w8[k] = (fr[k] * 256 + 32767) / 65535;
    end
    sb = chans_q;
    sg = grid_q * sb;
    sr = grid_q * sg;
    base = ix[0] * sr + ix[1] * sg + ix[2] * sb;
    for (int ch = 0; ch < n; ch++) begin
      sc = (map_q >> (3 * ch)) & 7;
      val = 0;
      if (sc < chans_q) begin
        o = base + sc;
        // corner k: bit 2 red, bit 1 green, bit 0 blue
        for (int k = 0; k < 8; k++)
          v[k] = lut_shadow[o + k[2] * sr + k[1] * sg + k[0] * sb];
        if (mode_q != 0) begin
          acc = v[0];
          if (fr[0] >= fr[1]) begin
            if (fr[1] >= fr[2]) begin
              acc += scaled_step(v[4] - v[0], fr[0]) + scaled_step(v[6] - v[4], fr[1])
                   + scaled_step(v[7] - v[6], fr[2]);
            end else if (fr[0] >= fr[2]) begin
              acc += scaled_step(v[4] - v[0], fr[0]) + scaled_step(v[5] - v[4], fr[2])
                   + scaled_step(v[7] - v[5], fr[1]);
            end else begin
              acc += scaled_step(v[1] - v[0], fr[2]) + scaled_step(v[5] - v[1], fr[0])
                   + scaled_step(v[7] - v[5], fr[1]);
            end
          end else begin
            if (fr[2] >= fr[1]) begin
              acc += scaled_step(v[1] - v[0], fr[2]) + scaled_step(v[3] - v[1], fr[1])
                   + scaled_step(v[7] - v[3], fr[0]);
            end else if (fr[2] >= fr[0]) begin
              acc += scaled_step(v[2] - v[0], fr[1]) + scaled_step(v[3] - v[2], fr[2])
                   + scaled_step(v[7] - v[3], fr[0]);
            end else begin
              acc += scaled_step(v[2] - v[0], fr[1]) + scaled_step(v[6] - v[2], fr[0])
                   + scaled_step(v[7] - v[6], fr[2]);
            end
          end
          val = (acc <= 0) ? 0 : (acc >= 65535) ? 65535 : acc;
        end else begin
          val = blend8(blend8(blend8(v[0], v[1], w8[2]), blend8(v[2], v[3], w8[2]), w8[1]),
                       blend8(blend8(v[4], v[5], w8[2]), blend8(v[6], v[7], w8[2]), w8[1]),
                       w8[0]);
        end
      end
      res.chan_index = ch[cl3_pkg::CHAN_W-1:0];
      res.chan_value = val[cl3_pkg::WORD_W-1:0];
      res.last = (ch + 1 == n);
      expected_q.push_back(res);
    end
  endtask

  // ------------------------------------------------------------------ drivers
  function automatic int pick_gap();
    if (idle_en && $urandom_range(0, 3) == 0) return $urandom_range(1, 16);
    return 0;
  endfunction

  // caller sits at a rising edge; returns at the edge that accepts the item
  task automatic send_item(input logic cmd, input logic [14:0] addr, input logic [15:0] word,
                           input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
    int gap;
    bit got;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.lut_addr <= addr;
    in_ch.lut_word <= word;
    in_ch.red_in   <= r;
    in_ch.green_in <= g;
    in_ch.blue_in  <= b;
    do begin
      @(negedge clk);
      got = in_ch.ready;
      @(posedge clk);
    end while (!got);
    if (cmd == cl3_pkg::CMD_LOAD) begin
      n_loads++;
      if (addr < cl3_pkg::LUT_DEPTH) lut_shadow[addr] = word;
    end else begin
      n_lookups++;
      predict_lookup(r, g, b);
    end
  endtask

  task automatic load_word(input int unsigned addr, input int unsigned word);
    send_item(cl3_pkg::CMD_LOAD, addr[14:0], word[15:0], 16'h0, 16'h0, 16'h0);
  endtask

  task automatic lookup(input int unsigned r, input int unsigned g, input int unsigned b);
    send_item(cl3_pkg::CMD_LOOKUP, 15'($urandom), 16'($urandom), r[15:0], g[15:0], b[15:0]);
  endtask

  // loads every stored channel at the eight corners of the cell a color falls in
  task automatic fill_cell(input int unsigned r, input int unsigned g, input int unsigned b);
    int unsigned gs1, pos, base;
    int unsigned ix[3], c[3];
    c[0] = r; c[1] = g; c[2] = b;
    gs1 = grid_q - 1;
    for (int k = 0; k < 3; k++) begin
      pos = c[k] * gs1;
      ix[k] = pos / 65535;
      if (ix[k] > gs1 - 1) ix[k] = gs1 - 1;
    end
    base = (ix[0] * grid_q * grid_q + ix[1] * grid_q + ix[2]) * chans_q;
    for (int k = 0; k < 8; k++)
      for (int s = 0; s < chans_q; s++)
        load_word(base + (k[2] * grid_q * grid_q + k[1] * grid_q + k[0]) * chans_q + s,
                  $urandom_range(0, 65535));
  endtask

  // lets results drain and covers lookups that emit nothing
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input cl3_pkg::cfg_idx_t idx, input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[cl3_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      cl3_pkg::CFG_GRID_SIZE:     grid_q  = data & 5'h1f;
      cl3_pkg::CFG_CHANNEL_COUNT: chans_q = data & 3'h7;
      cl3_pkg::CFG_INTERP_MODE:   mode_q  = data & 1'h1;
      cl3_pkg::CFG_CHANNEL_MAP:   map_q   = data & 18'h3ffff;
      cl3_pkg::CFG_OUT_CAPACITY:  cap_q   = data & 3'h7;
      default: ;
    endcase
  endtask

  task automatic set_all(input int unsigned gs, input int unsigned cc, input int unsigned md,
                         input int unsigned mp, input int unsigned cp);
    wait_quiet();
    write_reg(cl3_pkg::CFG_GRID_SIZE, gs);
    write_reg(cl3_pkg::CFG_CHANNEL_COUNT, cc);
    write_reg(cl3_pkg::CFG_INTERP_MODE, md);
    write_reg(cl3_pkg::CFG_CHANNEL_MAP, mp);
    write_reg(cl3_pkg::CFG_OUT_CAPACITY, cp);
    n_settings++;
  endtask

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_cnt <= $urandom_range(0, 15);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // handshake signals are stable from the falling edge to the accepting edge
  always @(negedge clk) begin
    chan_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: chan_index %0d chan_value %0d",
               out_ch.chan_index, out_ch.chan_value);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.chan_index !== e.chan_index) begin
          $error("chan_index expected %0d actual %0d", e.chan_index, out_ch.chan_index);
          errors++;
        end
        if (out_ch.chan_value !== e.chan_value) begin
          $error("chan_value expected %0d actual %0d", e.chan_value, out_ch.chan_value);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_fill_table();
    idle_en = 1'b0;
    for (int a = 0; a < FILL_WORDS; a++) load_word(a, $urandom_range(0, 65535));
  endtask

  task automatic test_directed();
    idle_en = 1'b1;
    // defaults: grid 17, 3 channels, trilinear, identity map
    fill_cell(0, 0, 0);
    lookup(0, 0, 0);
    fill_cell(65535, 65535, 65535);
    lookup(65535, 65535, 65535);
    fill_cell(65535, 0, 32768);
    lookup(65535, 0, 32768);
    // writes past the table are dropped
    load_word(cl3_pkg::LUT_DEPTH, 16'h1234);
    load_word(32767, 16'hffff);
    fill_cell(65535, 65535, 0);
    lookup(65535, 65535, 0);
    set_all(17, 3, 1, 18'o543210, 6);
    fill_cell(40000, 30000, 20000);
    lookup(40000, 30000, 20000);
    set_all(3, 6, 1, 18'o012345, 6);
    // all six tetrahedron orderings
    lookup(30000, 20000, 10000);
    lookup(30000, 10000, 20000);
    lookup(20000, 10000, 30000);
    lookup(10000, 20000, 30000);
    lookup(10000, 30000, 20000);
    lookup(20000, 30000, 10000);
    lookup(20000, 20000, 20000);
    lookup(65535, 65535, 65535);
    // grid 2 with map fields past the stored count, capacity above count
    set_all(2, 3, 0, 18'o776210, 6);
    lookup(32767, 65535, 1);
    lookup(0, 65535, 65535);
    set_all(2, 4, 1, 18'o000703, 1);
    lookup(12345, 54321, 65535);
    // out-of-range settings: lookups produce nothing
    set_all(1, 3, 0, 18'o543210, 6);
    lookup(100, 200, 300);
    set_all(18, 3, 0, 18'o543210, 6);
    lookup(100, 200, 300);
    set_all(17, 7, 0, 18'o543210, 6);
    lookup(100, 200, 300);
    set_all(17, 2, 0, 18'o543210, 6);
    lookup(100, 200, 300);
    set_all(17, 3, 0, 18'o543210, 0);
    lookup(100, 200, 300);
  endtask

  function automatic int unsigned rand_color();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic test_random();
    int unsigned gs, cc, mp, cp;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: gs = 3;
        1: gs = 2;
        default: gs = $urandom_range(2, 3);
      endcase
      cc = (ph == 0) ? 6 : (ph == 1) ? 3 : $urandom_range(3, 6);
      mp = 0;
      for (int f = 0; f < 6; f++)
        mp |= (($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                            : $urandom_range(0, cc - 1)) << (3 * f);
      cp = (ph == 2) ? 1 : (ph == 5) ? 7 : $urandom_range(1, 6);
      if (ph == 7) set_all($urandom_range(18, 31), cc, ph & 1, mp, cp);
      else set_all(gs, cc, ph & 1, mp, cp);
      idle_en = (ph < 11);
      for (int k = 0; k < 15; k++) begin
        if (ph == 3 && k == 8) wait_quiet();
        if ($urandom_range(0, 6) == 0) begin
          if ($urandom_range(0, 9) == 0) load_word($urandom_range(cl3_pkg::LUT_DEPTH, 32767),
                                                   $urandom_range(0, 65535));
          else load_word($urandom_range(0, cl3_pkg::LUT_DEPTH - 1), $urandom_range(0, 65535));
        end else begin
          lookup(rand_color(), rand_color(), rand_color());
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = cl3_pkg::CFG_GRID_SIZE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = cl3_pkg::CMD_LOAD;
    in_ch.lut_addr = '0;
    in_ch.lut_word = '0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    out_ch.ready = 1'b0;
    grid_q = 17; chans_q = 3; mode_q = 0; map_q = 181896; cap_q = 6;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_table();
    test_directed();
    test_random();

    idle_en = 1'b0;
    wait_quiet();
    $display("covered %0d lookups and %0d table loads over %0d register settings",
             n_lookups, n_loads, n_settings);
    $display("%0d result items checked", n_results);
    if (errors == 0) begin
      $display("color_lut3d_interpolator: match");
    end else begin
      $display("color_lut3d_interpolator: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("color_lut3d_interpolator: mismatch");
    $finish;
  end

endmodule
